/* rtl/s1md_pkg.sv */
// ----------------------------------------------------------------------------
// s1md_pkg
// Shared types and constants of the SHA-1 message digest unit.
// ----------------------------------------------------------------------------
`default_nettype none

package s1md_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] POS_LAST     = 6'd63;
  localparam logic [2:0] LEN_SLOT     = 3'd7;
  localparam logic [6:0] ROUND_LAST   = 7'd79;
  localparam logic [6:0] SCHED_START  = 7'd16;
  localparam logic [2:0] LAST_IDX     = 3'd4;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       step;
    logic       expand;
  } sched_ctl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       add;
    logic       reinit;
    logic [6:0] round;
    logic [2:0] rd_idx;
  } core_ctl_t;

endpackage

`default_nettype wire

/* rtl/s1md_if.sv */
// ----------------------------------------------------------------------------
// s1md_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface s1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface s1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

/* rtl/sha1_message_digest_unit.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 engine taking one message byte per word and returning the digest.
// ----------------------------------------------------------------------------
// msg carries one byte (has_byte), an end mark (end_of_message), or both;
// the byte is taken before the end mark. dig returns five 32-bit words,
// most significant first, word_index 0..4, last_word on the fifth.
// A byte that does not complete a 64-byte block leaves the unit ready for the
// next byte. The byte that completes a block is followed by 80 rounds of the
// single round unit at one round per cycle, and then by the chaining add.
// After the end mark, padding and length enter one byte per cycle up to the
// block end, then the block is compressed; a second block of padding and
// length follows when fewer than 9 bytes were left. The first digest word
// is offered in the cycle after the chaining add of the last block.
// msg.ready is low while a block is compressed, padded or read out.
// A stalled dig holds the current word; the unit waits.
// Reset restores the initial chaining value and clears the length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  s1md_in_if.sink     msg,
  s1md_out_if.source  dig
);
  import s1md_pkg::*;

  sched_ctl_t  sched_ctl;
  core_ctl_t   core_ctl;
  logic [31:0] wt;
  logic [2:0]  out_idx;

  s1md_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (msg.valid),
    .in_data_byte (msg.data_byte),
    .in_has_byte  (msg.has_byte),
    .in_end       (msg.end_of_message),
    .in_ready     (msg.ready),
    .out_ready    (dig.ready),
    .out_valid    (dig.valid),
    .out_idx      (out_idx),
    .sched_ctl    (sched_ctl),
    .core_ctl     (core_ctl)
  );

  s1md_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .wt  (wt)
  );

  s1md_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctl         (core_ctl),
    .wt          (wt),
    .digest_word (dig.digest_word)
  );

  assign dig.word_index = out_idx;
  assign dig.last_word  = (out_idx == LAST_IDX);

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    dig.valid |-> !msg.ready)
    else $error("input taken while digest pending");

  a_resume: assert property (@(posedge clk) disable iff (rst)
    (dig.valid && dig.ready && dig.last_word) |=> (msg.ready && !dig.valid))
    else $error("no return to intake after last digest word");

  a_word_step: assert property (@(posedge clk) disable iff (rst)
    (dig.valid && dig.ready && !dig.last_word) |=>
      (dig.valid && (dig.word_index == $past(dig.word_index) + 3'd1)))
    else $error("digest word skipped");
`endif

endmodule

`default_nettype wire

/* rtl/s1md_sched.sv */
// ----------------------------------------------------------------------------
// s1md_sched
// Sixteen-word block window: packs bytes big-endian and rolls the schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module s1md_sched (
  input  wire logic                 clk,
  input  wire s1md_pkg::sched_ctl_t ctl,
  output logic [31:0]               wt
);
  import s1md_pkg::*;

  logic [31:0] win [16];
  logic [31:0] mix;

  always_comb begin
    mix = win[13] ^ win[8] ^ win[2] ^ win[0];
    wt  = ctl.expand ? {mix[30:0], mix[31]} : win[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], ctl.byte_val};
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= wt;
    end
  end

endmodule

`default_nettype wire

/* rtl/s1md_core.sv */
// ----------------------------------------------------------------------------
// s1md_core
// Round unit with working variables and the five-word chaining value.
// ----------------------------------------------------------------------------
`default_nettype none

module s1md_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire s1md_pkg::core_ctl_t ctl,
  input  wire logic [31:0]         wt,
  output logic [31:0]              digest_word
);
  import s1md_pkg::*;

  logic [31:0] chain [5];
  logic [31:0] wv    [5];
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    case (ctl.round) inside
      [7'd0:7'd19]: begin
        f = (wv[1] & wv[2]) | (~wv[1] & wv[3]);
        k = K_0;
      end
      [7'd20:7'd39]: begin
        f = wv[1] ^ wv[2] ^ wv[3];
        k = K_1;
      end
      [7'd40:7'd59]: begin
        f = (wv[1] & wv[2]) | (wv[1] & wv[3]) | (wv[2] & wv[3]);
        k = K_2;
      end
      default: begin
        f = wv[1] ^ wv[2] ^ wv[3];
        k = K_3;
      end
    endcase
    tmp = {wv[0][26:0], wv[0][31:27]} + f + wv[4] + k + wt;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 5; i++) begin
        wv[i] <= chain[i];
      end
    end else if (ctl.step) begin
      wv[0] <= tmp;
      wv[1] <= wv[0];
      wv[2] <= {wv[1][1:0], wv[1][31:2]};
      wv[3] <= wv[2];
      wv[4] <= wv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= H_INIT;
    end else if (ctl.add) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= chain[i] + wv[i];
      end
    end else if (ctl.reinit) begin
      chain <= H_INIT;
    end
  end

  assign digest_word = chain[ctl.rd_idx];

endmodule

`default_nettype wire

/* rtl/s1md_ctrl.sv */
// ----------------------------------------------------------------------------
// s1md_ctrl
// Sequencer: byte intake, padding and length, round count, digest readout.
// ----------------------------------------------------------------------------
`default_nettype none

module s1md_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_has_byte,
  input  wire logic                  in_end,
  output logic                       in_ready,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [2:0]                 out_idx,
  output s1md_pkg::sched_ctl_t       sched_ctl,
  output s1md_pkg::core_ctl_t        core_ctl
);
  import s1md_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [6:0]  round;
  logic [5:0]  pad_pos;
  logic        first;
  logic        len_ok;
  logic        fin;
  logic        tail;
  logic [63:0] lenbits;
  logic [60:0] byte_count;
  logic [60:0] bc_inc;
  logic        accept;
  logic        len_field;
  logic        last_out;
  logic [7:0]  pad_byte;

  assign bc_inc    = byte_count + 61'(in_has_byte);
  assign accept    = in_valid && (state == ST_IDLE);
  assign len_field = len_ok && !first && (pad_pos[5:3] == LEN_SLOT);
  assign last_out  = out_ready && (out_idx == LAST_IDX);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte && (byte_count[5:0] == POS_LAST)) state_next = ST_ROUND;
          else if (in_end) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pad_pos == POS_LAST) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round == ROUND_LAST) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (fin) state_next = ST_OUT;
        else if (tail) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT: begin
        if (last_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);

    if (first) pad_byte = PAD_MARK;
    else if (len_field) pad_byte = lenbits[63:56];
    else pad_byte = 8'h00;

    sched_ctl.shift_byte = (accept && in_has_byte) || (state == ST_PAD);
    sched_ctl.byte_val   = (state == ST_PAD) ? pad_byte : in_data_byte;
    sched_ctl.step       = (state == ST_ROUND);
    sched_ctl.expand     = (round >= SCHED_START);

    core_ctl.load   = (state_next == ST_ROUND) && (state != ST_ROUND);
    core_ctl.step   = (state == ST_ROUND);
    core_ctl.add    = (state == ST_ADD);
    core_ctl.reinit = (state == ST_OUT) && last_out;
    core_ctl.round  = round;
    core_ctl.rd_idx = out_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round      <= '0;
      pad_pos    <= '0;
      first      <= 1'b0;
      len_ok     <= 1'b0;
      fin        <= 1'b0;
      tail       <= 1'b0;
      lenbits    <= '0;
      byte_count <= '0;
      out_idx    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          round <= '0;
          fin   <= 1'b0;
          if (accept) begin
            byte_count <= bc_inc;
            if (in_end) begin
              tail    <= 1'b1;
              first   <= 1'b1;
              lenbits <= {bc_inc, 3'b000};
              pad_pos <= bc_inc[5:0];
              len_ok  <= (bc_inc[5:3] != LEN_SLOT);
            end
          end
        end
        ST_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          round   <= '0;
          if (first) first <= 1'b0;
          else if (len_field) lenbits <= {lenbits[55:0], 8'h00};
          if (pad_pos == POS_LAST) fin <= len_ok;
        end
        ST_ROUND: begin
          round <= round + 7'd1;
        end
        ST_ADD: begin
          pad_pos <= '0;
          len_ok  <= 1'b1;
          out_idx <= '0;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == LAST_IDX) begin
              tail       <= 1'b0;
              fin        <= 1'b0;
              byte_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams and end marks into the SHA-1 digest unit and checks
// every digest word against a built-in SHA-1 predictor. The directed part
// covers the empty message, a byte arriving with the end mark, idle words
// and extreme byte values. The random part covers messages that end on the
// padding boundaries and short messages. The sender works in bursts, and the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned ITEM_TARGET    = 160;
  localparam int unsigned DIGEST_TARGET  = 12;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned DIGEST_WORDS   = 5;

  localparam logic [31:0] IV_0 = 32'h67452301;
  localparam logic [31:0] IV_1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_2 = 32'h98BADCFE;
  localparam logic [31:0] IV_3 = 32'h10325476;
  localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
  localparam logic [31:0] RK_0 = 32'h5A827999;
  localparam logic [31:0] RK_1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK_2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK_3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  class digest_scoreboard;
    logic [31:0]  chain_h [5];
    logic [31:0]  block_w [16];
    logic [60:0]  msg_bytes;
    digest_word_t digest_q [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  digests;

    function new();
      restart_chain();
      foreach (block_w[i]) block_w[i] = '0;
      mismatches = 0;
      checked = 0;
      digests = 0;
    endfunction

    function void restart_chain();
      chain_h[0] = IV_0;
      chain_h[1] = IV_1;
      chain_h[2] = IV_2;
      chain_h[3] = IV_3;
      chain_h[4] = IV_4;
      msg_bytes = '0;
    endfunction

    function void append_word(digest_word_t w);
      digest_q.insert(digest_q.size(), w);
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void put_byte(logic [5:0] pos, logic [7:0] b);
      int sh;
      sh = 24 - 8 * pos[1:0];
      block_w[pos[5:2]][sh +: 8] = b;
    endfunction

    function void compress_block();
      logic [31:0] a, b, c, d, e, f, k, w, tmp;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 16) begin
          w = block_w[r];
        end else begin
          w = rotl(block_w[(r - 3) % 16] ^ block_w[(r - 8) % 16] ^
                   block_w[(r - 14) % 16] ^ block_w[r % 16], 1);
          block_w[r % 16] = w;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = RK_0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = RK_1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = RK_2;
        end else begin
          f = b ^ c ^ d;
          k = RK_3;
        end
        tmp = rotl(a, 5) + f + e + k + w;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = tmp;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
    endfunction

    function void note_word(logic [7:0] data, logic has, logic eom);
      logic [5:0]  pos;
      logic [63:0] bit_len;
      if (has) begin
        pos = msg_bytes[5:0];
        put_byte(pos, data);
        msg_bytes = msg_bytes + 61'd1;
        if (pos == 6'd63) compress_block();
      end
      if (!eom) return;
      pos = msg_bytes[5:0];
      put_byte(pos, PAD_BYTE);
      if (pos >= 6'd56) begin
        // length does not fit: flush this block, then a fresh one
        for (int p = pos + 1; p < 64; p++) put_byte(p[5:0], 8'h00);
        compress_block();
        for (int p = 0; p < 56; p++) put_byte(p[5:0], 8'h00);
      end else begin
        for (int p = pos + 1; p < 56; p++) put_byte(p[5:0], 8'h00);
      end
      bit_len = {msg_bytes, 3'b000};
      block_w[14] = bit_len[63:32];
      block_w[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        append_word(digest_word_t'{word: chain_h[i], index: 3'(i),
                                   last: (i == DIGEST_WORDS - 1)});
      end
      digests++;
      restart_chain();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t want;
      checked++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected digest word: %h idx %0d last %0b", word, index, last);
        return;
      end
      want = digest_q.pop_front();
      if (want.word !== word || want.index !== index || want.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("digest word mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                   want.word, want.index, want.last, word, index, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  s1md_in_if  msg_ch ();
  s1md_out_if dig_ch ();

  sha1_message_digest_unit u_dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .dig (dig_ch)
  );

  digest_scoreboard sb;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    dig_ch.ready <= 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   dig_ch.ready <= 1'b1;
        RX_COIN:   dig_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: dig_ch.ready <= ($urandom_range(0, 7) == 0);
        default:   dig_ch.ready <= (mode_left % 3 != 0);
      endcase
    end
  end

  initial begin : monitor
    logic moved;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        moved = 1'b0;
        if (msg_ch.valid && msg_ch.ready) begin
          sb.note_word(msg_ch.data_byte, msg_ch.has_byte, msg_ch.end_of_message);
          moved = 1'b1;
        end
        if (dig_ch.valid && dig_ch.ready) begin
          sb.check_word(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
          moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] d, input logic h, input logic e);
    if (burst_left == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64)
                                                : $urandom_range(1, 8);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.data_byte      <= d;
    msg_ch.has_byte       <= h;
    msg_ch.end_of_message <= e;
    do @(posedge clk); while (!msg_ch.ready);
    burst_left--;
    if (h || e) items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (len == 0 || !end_on_byte) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int unsigned len;
    sb = new();
    burst_left = 0;
    items_sent = 0;
    rst <= 1'b1;
    msg_ch.valid          <= 1'b0;
    msg_ch.data_byte      <= 8'h00;
    msg_ch.has_byte       <= 1'b0;
    msg_ch.end_of_message <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty message, then "abc" with the end on its last byte
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    // idle word, extreme bytes, separate and combined end marks
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h7F, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hFE, 1'b0, 1'b0);
    send_word(8'hFE, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);

    // padding boundaries first, then mostly short messages
    send_message(55, 1'($urandom_range(0, 1)));
    send_message(56, 1'($urandom_range(0, 1)));
    send_message(64, 1'b1);
    while (items_sent < ITEM_TARGET || sb.digests < DIGEST_TARGET) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    msg_ch.valid <= 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes and end marks forming %0d messages, with bursty input.",
             items_sent, sb.digests);
    $display("Checked %0d digest words under receiver stalls, %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.digest_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
